// ===== sv/nsr_pkg.sv =====
package nsr_pkg;

  // Fixed-point format and iteration limits
  localparam int FRAC_BITS  = 16;
  localparam int MAX_STEPS  = 64;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 25;
  localparam int TOL_W      = 16;
  localparam int STAT_W     = 2;

  // Iterate and dividend both span the scaled radicand
  localparam int DIV_W      = RAD_W + FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);

  // Status codes
  localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO      = 2'd1;
  localparam logic [STAT_W-1:0] ST_CAP       = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_UPDATE
  } nsr_state_t;

endpackage

// ===== sv/newton_square_root.sv =====
// A zero radicand is answered in the cycle after start is taken. Otherwise each Newton
// step runs the one-bit-per-cycle restoring divider over the DIV_W quotient bits, then
// one update and convergence check; a root takes between 1 and 64 steps. A new radicand
// is taken while done is high, as the sequencer is then idle, but none while busy.
// Results appear for one cycle with done high; the receiver cannot stall them.
// Synchronous active-high rst sets tolerance to 7 and returns the sequencer to idle.
module newton_square_root import nsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [RAD_W-1:0]  radicand,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TOL_W-1:0]  tolerance,
  output logic              done,
  output logic [ROOT_W-1:0] root,
  output logic [STAT_W-1:0] status
);

  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_W - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS - 1);
  localparam logic [DIV_W-1:0]  ROOT_MAX  = DIV_W'((64'd1 << ROOT_W) - 64'd1);

  nsr_state_t        state, state_next;
  logic [TOL_W-1:0]  tol;
  logic [RAD_W-1:0]  rad, rad_next;
  logic [DIV_W-1:0]  x, x_next;
  logic [DIV_W-1:0]  dvd, dvd_next;
  logic [DIV_W:0]    rem, rem_next;
  logic [DCNT_W-1:0] dcnt, dcnt_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic              done_next;
  logic [ROOT_W-1:0] root_next;
  logic [STAT_W-1:0] status_next;

  // Shared datapath terms
  logic [DIV_W:0]    rem_sh, rem_sub;
  logic              q_bit;
  logic [DIV_W:0]    sum;
  logic [DIV_W-1:0]  x_new, diff;
  logic              conv;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(7);
    end else if (cfg_valid && cfg_ready) begin
      tol <= tolerance;
    end
  end

  // Divider step, Newton update and convergence check
  always_comb begin
    rem_sh  = {rem[DIV_W-1:0], dvd[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, x};
    q_bit   = (rem_sh >= {1'b0, x});
    sum     = {1'b0, x} + {1'b0, dvd};
    x_new   = sum[DIV_W:1];
    if (x_new == '0) begin
      x_new = DIV_W'(1);
    end
    diff    = (x_new >= x) ? (x_new - x) : (x - x_new);
    conv    = (diff <= {{(DIV_W-TOL_W){1'b0}}, tol});
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    rad_next    = rad;
    x_next      = x;
    dvd_next    = dvd;
    rem_next    = rem;
    dcnt_next   = dcnt;
    steps_next  = steps;
    done_next   = 1'b0;
    root_next   = root;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (radicand == '0) begin
            done_next   = 1'b1;
            root_next   = '0;
            status_next = ST_ZERO;
          end else begin
            rad_next   = radicand;
            x_next     = {{FRAC_BITS{1'b0}}, radicand};
            dvd_next   = {radicand, {FRAC_BITS{1'b0}}};
            rem_next   = '0;
            dcnt_next  = '0;
            steps_next = '0;
            state_next = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        // shift one quotient bit per cycle
        rem_next  = q_bit ? rem_sub : rem_sh;
        dvd_next  = {dvd[DIV_W-2:0], q_bit};
        dcnt_next = dcnt + 1'b1;
        if (dcnt == DCNT_LAST) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // dvd now holds the quotient
        x_next     = x_new;
        steps_next = steps + 1'b1;
        if (conv || steps == STEP_LAST) begin
          done_next   = 1'b1;
          root_next   = (x_new > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : x_new[ROOT_W-1:0];
          status_next = conv ? ST_CONVERGED : ST_CAP;
          state_next  = S_IDLE;
        end else begin
          dvd_next   = {rad, {FRAC_BITS{1'b0}}};
          rem_next   = '0;
          dcnt_next  = '0;
          state_next = S_DIVIDE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rad    <= rad_next;
    x      <= x_next;
    dvd    <= dvd_next;
    rem    <= rem_next;
    dcnt   <= dcnt_next;
    steps  <= steps_next;
    root   <= root_next;
    status <= status_next;
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while sequencer busy");

  a_start_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted radicand neither started nor answered");

  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_ZERO) |-> (root == '0))
    else $error("zero radicand gave nonzero root");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_CONVERGED || status == ST_ZERO || status == ST_CAP))
    else $error("undefined status code");

endmodule

// ===== dv/tb_newton_square_root.sv =====
`timescale 1ns / 100ps

module tb_newton_square_root;
  import nsr_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int MAX_GAP      = 14;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [STAT_W-1:0] status;
  } root_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [RAD_W-1:0]  radicand;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TOL_W-1:0]  tolerance;
  logic              done;
  logic [ROOT_W-1:0] root;
  logic [STAT_W-1:0] status;

  root_result_t      root_expect_q[$];
  logic [TOL_W-1:0]  tol_setting;
  int                mismatch_count;
  int                cycle_count;

  newton_square_root dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .radicand  (radicand),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .tolerance (tolerance),
    .done      (done),
    .root      (root),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Newton iteration from x = n with truncating divide and halving
  function automatic root_result_t predict_root(input logic [RAD_W-1:0] n,
                                                input logic [TOL_W-1:0] tol);
    root_result_t     res;
    longint unsigned  scaled;
    longint unsigned  x;
    longint unsigned  q;
    longint unsigned  next_x;
    longint unsigned  diff;
    longint unsigned  root_limit;
    res.status = ST_CAP;
    root_limit = (64'd1 << ROOT_W) - 64'd1;
    if (n == '0) begin
      res.root   = '0;
      res.status = ST_ZERO;
      return res;
    end
    scaled = longint'(n) << FRAC_BITS;
    x      = longint'(n);
    for (int step = 0; step < MAX_STEPS; step++) begin
      q      = scaled / x;
      next_x = (x + q) >> 1;
      // keep the divisor nonzero
      if (next_x == 0) next_x = 1;
      diff = (next_x >= x) ? (next_x - x) : (x - next_x);
      x    = next_x;
      if (diff <= longint'(tol)) begin
        res.status = ST_CONVERGED;
        break;
      end
    end
    res.root = (x > root_limit) ? root_limit[ROOT_W-1:0] : x[ROOT_W-1:0];
    return res;
  endfunction

  // Mix of radicand shapes: zeros, small values, exact squares, oscillating forms, powers of two, full-range random
  function automatic logic [RAD_W-1:0] pick_radicand();
    logic [RAD_W-1:0] m;
    logic [RAD_W-1:0] n;
    case ($urandom_range(0, 9))
      0: n = '0;
      1: n = $urandom_range(1, 65535);
      2: begin
        m = $urandom_range(1, 255);
        n = (m * m) << FRAC_BITS;
      end
      3: begin
        // (256*m)^2 +/- 2*m patterns near exact squares, aimed at making the integer iterate ping-pong
        m = $urandom_range(1, 255);
        n = $urandom_range(0, 1) ? ((m * m) << FRAC_BITS) + 2 * m
                                 : ((m * m) << FRAC_BITS) - 2 * m;
      end
      4: n = 32'd1 << $urandom_range(0, 31);
      default: n = $urandom;
    endcase
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  // Send one radicand beat after a random gap; start stays high on return
  task automatic send_radicand(input logic [RAD_W-1:0] value);
    int gap;
    gap = $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    radicand <= value;
    do @(posedge clk); while (busy);
    root_expect_q.push_back(predict_root(value, tol_setting));
  endtask

  // Drop start, then write tolerance once the block has drained
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (root_expect_q.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    tolerance <= value;
    do @(posedge clk); while (!cfg_ready);
    tol_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_tolerance();
    send_radicand(32'h0000_0001);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0004_0000);
    send_radicand(32'h8000_0000);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h0000_0002);
    send_radicand(32'h0000_FFFF);
  endtask

  task automatic test_zero_radicand();
    send_radicand(32'h0000_0000);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0000_0000);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(16'hFFFF);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0000_0003);
    write_tolerance(16'd1);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'hC000_0000);
  endtask

  // Tolerance zero demands an exact repeat; oscillating iterates hit the step cap
  task automatic test_exact_repeat();
    write_tolerance(16'd0);
    send_radicand(32'd65534);
    send_radicand(32'd16385);
    send_radicand(32'd65538);
    send_radicand(32'h0001_0000);
    send_radicand(32'hFFFF_FFFF);
  endtask

  task automatic run_random_phase(input logic [TOL_W-1:0] tol, input int count);
    write_tolerance(tol);
    repeat (count) send_radicand(pick_radicand());
  endtask

  task automatic test_random_tolerances();
    run_random_phase($urandom_range(1, 65535), 120);
    run_random_phase(16'd1, 90);
    run_random_phase(16'hFFFF, 90);
    run_random_phase(16'd0, 40);
    run_random_phase(16'd7, 120);
    run_random_phase($urandom_range(0, 255), 100);
  endtask

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin : check_results
    root_result_t want;
    if (!rst && done) begin
      if (root_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result root=%0h status=%0d", root, status));
      end else begin
        want = root_expect_q.pop_front();
        if (root !== want.root || status !== want.status)
          report_mismatch($sformatf("root exp=%0h got=%0h, status exp=%0d got=%0d",
                                    want.root, root, want.status, status));
      end
    end
  end

  // End the run if it stalls
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    radicand       = '0;
    cfg_valid      = 1'b0;
    tolerance      = '0;
    tol_setting    = 16'd7;
    mismatch_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_tolerance();
    test_zero_radicand();
    test_tolerance_extremes();
    test_exact_repeat();
    test_random_tolerances();

    // Drop start, drain, then allow for stray beats
    @(negedge clk);
    start <= 1'b0;
    while (root_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && root_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
